/* src/linear_rect_interpolator_assert.svh */
// Assertion macros shared by the interpolator RTL.
`ifndef LINEAR_RECT_INTERPOLATOR_ASSERT_SVH
`define LINEAR_RECT_INTERPOLATOR_ASSERT_SVH

// same-cycle implication
`define LRI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LRI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/lri_pkg.sv */
// Types and constants of the linear rectangle interpolator.
`default_nettype none
package lri_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int FRAME_BITS    = 16;
    localparam int RECT_W        = 32;
    localparam int PIX_W         = 16;
    localparam int DIFF_W        = PIX_W + 1;
    localparam int MAG_W         = PIX_W + FRACTION_BITS;
    localparam int CNT_W         = $clog2(MAG_W + 1);
    localparam int LANES         = 4;
    localparam int LANE_W        = 2;

    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_START,
        S_DIV_WAIT,
        S_TICK,
        S_EMIT
    } lri_state_t;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage
`default_nettype wire

/* src/lri_div.sv */
// Shared restoring divider: signed fixed-point difference over frame count, one bit per cycle.
`default_nettype none
module lri_div
    import lri_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire div_ctrl_t                ctrl,
    input  wire logic signed [DIFF_W-1:0] dividend,
    input  wire logic [FRAME_BITS-1:0]    divisor,
    output div_stat_t                     stat,
    output logic [RECT_W-1:0]             quotient
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  neg_reg;
    logic [MAG_W-1:0]      num_reg;
    logic [FRAME_BITS-1:0] rem_reg;
    logic [FRAME_BITS-1:0] div_reg;

    logic [DIFF_W-1:0]     mag;
    logic [FRAME_BITS:0]   rs;
    logic [FRAME_BITS:0]   rs_sub;
    logic                  ge;
    logic signed [63:0]    q_wide;

    assign mag    = dividend[DIFF_W-1] ? DIFF_W'(-dividend) : DIFF_W'(dividend);
    assign rs     = {rem_reg, num_reg[MAG_W-1]};
    assign rs_sub = rs - {1'b0, div_reg};
    assign ge     = rs >= {1'b0, div_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (ctrl.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(MAG_W);
        end else if (busy_reg) begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            neg_reg <= dividend[DIFF_W-1];
            num_reg <= {mag[PIX_W-1:0], {FRACTION_BITS{1'b0}}};
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            num_reg <= {num_reg[MAG_W-2:0], ge};
            rem_reg <= ge ? rs_sub[FRAME_BITS-1:0] : rs[FRAME_BITS-1:0];
        end
    end

    always_comb begin
        q_wide = 64'($signed({1'b0, num_reg}));
        if (neg_reg) begin
            q_wide = -q_wide;
        end
    end

    assign quotient  = q_wide[RECT_W-1:0];
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
`default_nettype wire

/* src/linear_rect_interpolator.sv */
// Top level: linear rectangle interpolator with sequencer and shared divider.
// Start transaction: result follows four back-to-back passes, one per lane, through the
//   one-bit-per-cycle divider.
// Tick while running: one shared adder steps the four lanes in turn before the result.
// Tick while idle: no step. One transaction in flight; the next waits until its result is emitted.
// Reset (aresetn low, synchronous): rectangle, steps, frame count and flags clear to zero.
`default_nettype none
module linear_rect_interpolator
    import lri_pkg::*;
(
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_opcode,
    input  wire logic signed [PIX_W-1:0]      s_start_x,
    input  wire logic signed [PIX_W-1:0]      s_start_y,
    input  wire logic signed [PIX_W-1:0]      s_start_w,
    input  wire logic signed [PIX_W-1:0]      s_start_h,
    input  wire logic signed [PIX_W-1:0]      s_dest_x,
    input  wire logic signed [PIX_W-1:0]      s_dest_y,
    input  wire logic signed [PIX_W-1:0]      s_dest_w,
    input  wire logic signed [PIX_W-1:0]      s_dest_h,
    input  wire logic [PIX_W-1:0]             s_frame_count,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed [RECT_W-1:0]          m_pos_x,
    output logic signed [RECT_W-1:0]          m_pos_y,
    output logic signed [RECT_W-1:0]          m_size_w,
    output logic signed [RECT_W-1:0]          m_size_h,
    output logic                              m_active,
    output logic                              m_finished
);

    `include "linear_rect_interpolator_assert.svh"

    lri_state_t              state_reg, state_next;
    logic [LANE_W-1:0]       lane_reg;
    logic [RECT_W-1:0]       cur_reg  [LANES];
    logic [RECT_W-1:0]       step_reg [LANES];
    logic signed [DIFF_W-1:0] diff_reg [LANES];
    logic [FRAME_BITS-1:0]   frames_left_reg;
    logic                    running_reg;
    logic                    finished_reg;
    logic                    m_valid_reg;

    logic                    s_fire;
    logic                    out_free;
    logic                    emit;
    logic                    last_lane;
    logic [FRAME_BITS-1:0]   frames_in;
    div_ctrl_t               div_ctrl;
    div_stat_t               div_stat;
    logic [RECT_W-1:0]       div_quot;

    lri_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (div_ctrl),
        .dividend (diff_reg[lane_reg]),
        .divisor  (frames_left_reg),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    assign s_fire    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign last_lane = lane_reg == LANE_W'(LANES - 1);
    assign frames_in = (s_frame_count[FRAME_BITS-1:0] == '0) ? FRAME_BITS'(1)
                                                             : s_frame_count[FRAME_BITS-1:0];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    if (s_opcode == OP_START) begin
                        state_next = S_DIV_START;
                    end else if (running_reg) begin
                        state_next = S_TICK;
                    end else begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_DIV_START: state_next = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (div_stat.done) begin
                    state_next = last_lane ? S_EMIT : S_DIV_START;
                end
            end
            S_TICK: begin
                if (last_lane) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready        = 1'b0;
        div_ctrl.start = 1'b0;
        emit           = 1'b0;
        unique case (state_reg)
            S_IDLE:      s_ready = 1'b1;
            S_DIV_START: div_ctrl.start = 1'b1;
            S_EMIT:      emit = out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            lane_reg        <= '0;
            frames_left_reg <= '0;
            running_reg     <= 1'b0;
            finished_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
            for (int i = 0; i < LANES; i++) begin
                cur_reg[i]  <= '0;
                step_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (s_fire) begin
                lane_reg     <= '0;
                finished_reg <= 1'b0;
                if (s_opcode == OP_START) begin
                    cur_reg[0]      <= RECT_W'($signed(s_start_x)) <<< FRACTION_BITS;
                    cur_reg[1]      <= RECT_W'($signed(s_start_y)) <<< FRACTION_BITS;
                    cur_reg[2]      <= RECT_W'($signed(s_start_w)) <<< FRACTION_BITS;
                    cur_reg[3]      <= RECT_W'($signed(s_start_h)) <<< FRACTION_BITS;
                    frames_left_reg <= frames_in;
                    running_reg     <= 1'b1;
                end
            end
            if (state_reg == S_DIV_WAIT && div_stat.done) begin
                step_reg[lane_reg] <= div_quot;
                lane_reg           <= lane_reg + LANE_W'(1);
            end
            if (state_reg == S_TICK) begin
                cur_reg[lane_reg] <= cur_reg[lane_reg] + step_reg[lane_reg];
                lane_reg          <= lane_reg + LANE_W'(1);
                if (last_lane) begin
                    frames_left_reg <= frames_left_reg - FRAME_BITS'(1);
                    if (frames_left_reg == FRAME_BITS'(1)) begin
                        running_reg  <= 1'b0;
                        finished_reg <= 1'b1;
                    end
                end
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && s_opcode == OP_START) begin
            diff_reg[0] <= DIFF_W'(s_dest_x) - DIFF_W'(s_start_x);
            diff_reg[1] <= DIFF_W'(s_dest_y) - DIFF_W'(s_start_y);
            diff_reg[2] <= DIFF_W'(s_dest_w) - DIFF_W'(s_start_w);
            diff_reg[3] <= DIFF_W'(s_dest_h) - DIFF_W'(s_start_h);
        end
        if (emit) begin
            m_pos_x    <= cur_reg[0];
            m_pos_y    <= cur_reg[1];
            m_size_w   <= cur_reg[2];
            m_size_h   <= cur_reg[3];
            m_active   <= running_reg;
            m_finished <= finished_reg;
        end
    end

    assign m_valid = m_valid_reg;

    `LRI_ASSERT_NOW(a_done_not_active, m_valid && m_finished, !m_active,
        "finished transaction reports active")
    `LRI_ASSERT_NOW(a_idle_div, s_ready, !div_stat.busy,
        "input ready while divider busy")
    `LRI_ASSERT_NEXT(a_start_div, s_fire && s_opcode == OP_START, div_ctrl.start,
        "start transaction did not launch divider")
    `LRI_ASSERT_NOW(a_running_frames, running_reg, frames_left_reg != '0,
        "running with no frames left")

endmodule
`default_nettype wire

/* test/tb_linear_rect_interpolator.sv */
// Self-checking testbench for the linear rectangle interpolator: directed and random animations.
`timescale 1ns / 1ps

module tb_linear_rect_interpolator;
    import lri_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_SHOWN      = 10;
    localparam int TOTAL_ITEMS    = 550;
    localparam int TAIL_CYCLES    = 20;

    typedef struct packed {
        logic                    op;
        logic signed [PIX_W-1:0] sx, sy, sw, sh;
        logic signed [PIX_W-1:0] dx, dy, dw, dh;
        logic [PIX_W-1:0]        frames;
    } anim_cmd_t;

    typedef struct packed {
        logic signed [RECT_W-1:0] x, y, w, h;
        logic                     active;
        logic                     finished;
    } rect_state_t;

    logic                     aclk          = 1'b0;
    logic                     aresetn       = 1'b0;
    logic                     s_valid       = 1'b0;
    logic                     s_ready;
    logic                     s_opcode      = OP_TICK;
    logic signed [PIX_W-1:0]  s_start_x     = '0;
    logic signed [PIX_W-1:0]  s_start_y     = '0;
    logic signed [PIX_W-1:0]  s_start_w     = '0;
    logic signed [PIX_W-1:0]  s_start_h     = '0;
    logic signed [PIX_W-1:0]  s_dest_x      = '0;
    logic signed [PIX_W-1:0]  s_dest_y      = '0;
    logic signed [PIX_W-1:0]  s_dest_w      = '0;
    logic signed [PIX_W-1:0]  s_dest_h      = '0;
    logic [PIX_W-1:0]         s_frame_count = '0;
    logic                     m_valid;
    logic                     m_ready       = 1'b0;
    logic signed [RECT_W-1:0] m_pos_x;
    logic signed [RECT_W-1:0] m_pos_y;
    logic signed [RECT_W-1:0] m_size_w;
    logic signed [RECT_W-1:0] m_size_h;
    logic                     m_active;
    logic                     m_finished;

    // predictor state
    logic [RECT_W-1:0]     rect_acc [LANES]  = '{default: '0};
    logic [RECT_W-1:0]     rect_step [LANES] = '{default: '0};
    logic [FRAME_BITS-1:0] frames_left       = '0;
    logic                  anim_running      = 1'b0;

    rect_state_t expected_q [$];
    int          err_count   = 0;
    int          items_sent  = 0;
    int          idle_cycles = 0;
    int          rx_stall    = 0;
    bit          tx_calm     = 1'b0;
    bit          rx_calm     = 1'b0;

    always #10 aclk = ~aclk;

    linear_rect_interpolator u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_start_x     (s_start_x),
        .s_start_y     (s_start_y),
        .s_start_w     (s_start_w),
        .s_start_h     (s_start_h),
        .s_dest_x      (s_dest_x),
        .s_dest_y      (s_dest_y),
        .s_dest_w      (s_dest_w),
        .s_dest_h      (s_dest_h),
        .s_frame_count (s_frame_count),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pos_x       (m_pos_x),
        .m_pos_y       (m_pos_y),
        .m_size_w      (m_size_w),
        .m_size_h      (m_size_h),
        .m_active      (m_active),
        .m_finished    (m_finished)
    );

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80) return $urandom_range(1, 3);
        if (roll < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic signed [PIX_W-1:0] rand_pix();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return $urandom_range(0, 1) ? 16'sh0000 : 16'shFFFF;
            3, 4: return PIX_W'(int'($urandom_range(0, 200)) - 100);
            default: return PIX_W'($urandom);
        endcase
    endfunction

    function automatic anim_cmd_t rand_cmd(input logic op, input int frames);
        anim_cmd_t c;
        c.op     = op;
        c.sx     = rand_pix();
        c.sy     = rand_pix();
        c.sw     = rand_pix();
        c.sh     = rand_pix();
        c.dx     = rand_pix();
        c.dy     = rand_pix();
        c.dw     = rand_pix();
        c.dh     = rand_pix();
        c.frames = PIX_W'(frames);
        return c;
    endfunction

    // Steps the rectangle animation by one command and returns the rectangle it reports.
    function automatic rect_state_t advance_rect_anim(input anim_cmd_t c);
        logic signed [PIX_W-1:0] from_v [LANES];
        logic signed [PIX_W-1:0] to_v [LANES];
        longint                  scale;
        longint                  span;
        longint                  nfr;
        rect_state_t             r;
        from_v     = '{c.sx, c.sy, c.sw, c.sh};
        to_v       = '{c.dx, c.dy, c.dw, c.dh};
        scale      = longint'(1) << FRACTION_BITS;
        r.finished = 1'b0;
        if (c.op == OP_START) begin
            nfr = longint'(c.frames[FRAME_BITS-1:0]);
            if (nfr == 0) nfr = 1;
            for (int i = 0; i < LANES; i++) begin
                span         = (longint'(to_v[i]) - longint'(from_v[i])) * scale;
                rect_acc[i]  = RECT_W'(longint'(from_v[i]) * scale);
                rect_step[i] = RECT_W'(span / nfr);
            end
            frames_left  = FRAME_BITS'(nfr);
            anim_running = 1'b1;
        end else if (anim_running) begin
            for (int i = 0; i < LANES; i++) begin
                rect_acc[i] = rect_acc[i] + rect_step[i];
            end
            frames_left = frames_left - 1'b1;
            if (frames_left == 0) begin
                anim_running = 1'b0;
                r.finished   = 1'b1;
            end
        end
        r.x      = rect_acc[0];
        r.y      = rect_acc[1];
        r.w      = rect_acc[2];
        r.h      = rect_acc[3];
        r.active = anim_running;
        return r;
    endfunction

    function automatic void log_failure(input string msg);
        err_count++;
        if (err_count <= MAX_SHOWN) $display("%s", msg);
    endfunction

    task automatic send_cmd(input anim_cmd_t c);
        bit hit;
        int gap;
        gap = (tx_calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_opcode      <= c.op;
        s_start_x     <= c.sx;
        s_start_y     <= c.sy;
        s_start_w     <= c.sw;
        s_start_h     <= c.sh;
        s_dest_x      <= c.dx;
        s_dest_y      <= c.dy;
        s_dest_w      <= c.dw;
        s_dest_h      <= c.dh;
        s_frame_count <= c.frames;
        // inputs only move at the rising edge, so ready at the falling edge decides the next one
        do begin
            @(negedge aclk);
            hit = s_ready;
            if (hit) expected_q.push_back(advance_rect_anim(c));
            @(posedge aclk);
        end while (!hit);
        items_sent++;
    endtask

    task automatic send_start(input int sx, input int sy, input int sw, input int sh,
                              input int dx, input int dy, input int dw, input int dh,
                              input int frames);
        anim_cmd_t c;
        c = '{OP_START, PIX_W'(sx), PIX_W'(sy), PIX_W'(sw), PIX_W'(sh),
              PIX_W'(dx), PIX_W'(dy), PIX_W'(dw), PIX_W'(dh), PIX_W'(frames)};
        send_cmd(c);
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_cmd(rand_cmd(OP_TICK, $urandom_range(0, 65535)));
    endtask

    task automatic wait_results();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (rx_stall > 0) begin
            m_ready  <= 1'b0;
            rx_stall <= rx_stall - 1;
        end else begin
            m_ready <= 1'b1;
            if (!rx_calm && $urandom_range(0, 3) == 0) rx_stall <= pick_gap();
        end
    end

    // result check and watchdog, sampled mid-cycle
    always @(negedge aclk) begin
        rect_state_t want;
        if (aresetn && ((s_valid && s_ready) || (m_valid && m_ready))) idle_cycles = 0;
        else idle_cycles++;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                log_failure($sformatf("unexpected result: x=%h y=%h w=%h h=%h act=%b fin=%b",
                    m_pos_x, m_pos_y, m_size_w, m_size_h, m_active, m_finished));
            end else begin
                want = expected_q.pop_front();
                if (m_pos_x !== want.x || m_pos_y !== want.y || m_size_w !== want.w ||
                        m_size_h !== want.h || m_active !== want.active ||
                        m_finished !== want.finished) begin
                    log_failure($sformatf(
                        "mismatch: exp x=%h y=%h w=%h h=%h act=%b fin=%b, got x=%h y=%h w=%h h=%h act=%b fin=%b",
                        want.x, want.y, want.w, want.h, want.active, want.finished,
                        m_pos_x, m_pos_y, m_size_w, m_size_h, m_active, m_finished));
                end
            end
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic test_idle_ticks();
        send_ticks(2);
    endtask

    task automatic test_extremes();
        // widest span in one frame: step wraps, sum still lands on the destination
        send_start(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767, 1);
        send_ticks(2);
        // zero frame count acts as one
        send_start(32767, 0, -1, 32767, -32768, 0, 1, -32768, 0);
        send_ticks(2);
        send_start(-32768, 32767, 0, -32768, 32767, -32768, 0, 32767, 65535);
        send_ticks(3);
        // restart mid-animation, uneven steps truncate toward zero
        send_start(0, 5, -7, 100, -1, -5, 7, 99, 3);
        send_ticks(4);
        send_start(10, -10, 1, -1, 11, -11, 0, 0, 32768);
        send_start(1, 2, 3, 4, 5, 6, 7, 8, 2);
        send_ticks(2);
        wait_results();
    endtask

    task automatic test_random_anims();
        int roll;
        int frames;
        int span;
        int ticks;
        while (items_sent < TOTAL_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 70) frames = $urandom_range(0, 12);
            else if (roll < 90) frames = $urandom_range(13, 40);
            else frames = $urandom_range(0, 65535);
            tx_calm = ($urandom_range(0, 4) == 0);
            rx_calm = ($urandom_range(0, 4) == 0);
            send_cmd(rand_cmd(OP_START, frames));
            span = (frames == 0) ? 1 : frames;
            if (span > 40) span = 40;
            if ($urandom_range(0, 99) < 15) ticks = $urandom_range(0, span - 1);
            else ticks = span + $urandom_range(0, 2);
            send_ticks(ticks);
            if ($urandom_range(0, 19) == 0) wait_results();
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        test_idle_ticks();
        test_extremes();
        test_random_anims();
        wait_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/lri_pkg.sv
src/lri_div.sv
src/linear_rect_interpolator.sv
test/tb_linear_rect_interpolator.sv
